### src/krhp_pkg.sv
// Shared types and constants for the key remap block.
package krhp_pkg;

	localparam int CODE_W    = 10;
	localparam int VALUE_W   = 2;
	localparam int SPEED_W   = 12;
	localparam int DELTA_W   = 8;
	localparam int CLICKS_W  = 12;
	localparam int HIRES_W   = 18;
	localparam int REM_W     = 9;
	localparam int ACC_W     = 20;
	localparam int MAP_CNT_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 20;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_PAIR0    = 3'd2;

	localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd256;

	localparam logic MODE_KEY   = 1'b0;
	localparam logic MODE_WHEEL = 1'b1;

	localparam logic KIND_KEY    = 1'b0;
	localparam logic KIND_SCROLL = 1'b1;

	localparam logic [VALUE_W-1:0] KEY_RELEASE = 2'd0;

	// hi-res units per wheel click
	localparam logic signed [HIRES_W-1:0] CLICK_HIRES = 18'sd120;

	// one pinned physical/virtual pair
	typedef struct packed {
		logic [CODE_W-1:0] virt;
		logic [CODE_W-1:0] phys;
	} held_entry_t;

	// remap register layout: target in the upper half
	typedef struct packed {
		logic [CODE_W-1:0] target;
		logic [CODE_W-1:0] source;
	} map_pair_t;

endpackage

### src/krhp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module krhp_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/key_remap_with_held_pinning_top.sv
// Key remap with held-key pinning and fractional wheel scaling: top level.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+--------------------------------------
//  in       | input     | in_valid / in_ready    | mode, key_code, key_value, wheel_delta
//  out      | output    | out_valid / out_ready  | event_kind, virtual_code,
//           |           |                        | virtual_value, scroll_clicks,
//           |           |                        | scroll_hires
//  cfg      | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// Sequence: a key transaction walks the held table through the single RAM read
// port, one entry per cycle. A pinned key that is released then reads the last
// held entry and moves it into the freed slot (unpin). A key that is not pinned
// walks the remap table one pair per cycle until the first hit or the end, and
// a press is then pinned while the held table has room. Last, the output
// register is loaded. A wheel transaction steps through multiply, divide by 256
// toward zero, scale by 120 and load. A zero delta ends after the multiply, zero
// clicks after the divide, with no result.
// The 10-bit comparator is the shared unit.
// Reset: arst_n clears the sequencer, held_count, the wheel remainder, the
// configuration registers and the output valid. The held table RAM is not
// cleared; only entries below held_count are ever read.
// Stalls: in_ready is high only while the sequencer is idle. A finished
// result waits in the output register, so a new transaction is taken while
// out_valid is still high; the sequencer stalls at its load step only when
// the output register is still full and out_ready is low.
module key_remap_with_held_pinning_top
	import krhp_pkg::*;
#(
	parameter int HELD_SLOTS  = 8,
	parameter int MAP_ENTRIES = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DAT_W-1:0]       cfg_wdata,
	// input channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic [CODE_W-1:0]          key_code,
	input  logic [VALUE_W-1:0]         key_value,
	input  logic signed [DELTA_W-1:0]  wheel_delta,
	// output channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       event_kind,
	output logic [CODE_W-1:0]          virtual_code,
	output logic [VALUE_W-1:0]         virtual_value,
	output logic signed [CLICKS_W-1:0] scroll_clicks,
	output logic signed [HIRES_W-1:0]  scroll_hires
);

	// held table address and count widths
	localparam int AW  = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
	localparam int CW  = $clog2(HELD_SLOTS + 1);
	localparam int MIW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_HSCAN  = 4'd1;  // walk held table
	localparam logic [3:0] S_RDLAST = 4'd2;  // read last held entry
	localparam logic [3:0] S_MOVE   = 4'd3;  // move last entry into freed slot
	localparam logic [3:0] S_MSCAN  = 4'd4;  // walk remap table
	localparam logic [3:0] S_PIN    = 4'd5;  // append pinned pair
	localparam logic [3:0] S_WMUL   = 4'd6;  // delta * speed + remainder
	localparam logic [3:0] S_WDIV   = 4'd7;  // split into clicks and fraction
	localparam logic [3:0] S_WHI    = 4'd8;  // clicks * 120
	localparam logic [3:0] S_EMIT   = 4'd9;  // load output register

	logic [3:0] state_q;

	// configuration registers
	logic [MAP_CNT_W-1:0]       map_count_q;
	logic signed [SPEED_W-1:0]  speed_q;
	map_pair_t                  pair_q [MAP_ENTRIES];

	// captured transaction
	logic                       mode_q;
	logic [CODE_W-1:0]          phys_q;
	logic [VALUE_W-1:0]         val_q;
	logic signed [DELTA_W-1:0]  delta_q;

	// key path working state
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              scan_q;
	logic                       rd_pend_s1;
	logic [AW-1:0]              rd_idx_s1;
	logic                       found_q;
	logic [AW-1:0]              idx_q;
	logic [CODE_W-1:0]          to_q;
	logic [MAP_CNT_W-1:0]       mscan_q;
	logic [MAP_CNT_W-1:0]       lim_q;

	// wheel path working state
	logic signed [REM_W-1:0]    rem_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [CLICKS_W-1:0] clicks_q;
	logic signed [HIRES_W-1:0]  hires_q;

	// output register
	logic                       out_valid_q;
	logic                       kind_o_q;
	logic [CODE_W-1:0]          code_o_q;
	logic [VALUE_W-1:0]         value_o_q;
	logic signed [CLICKS_W-1:0] clicks_o_q;
	logic signed [HIRES_W-1:0]  hires_o_q;

	// held table RAM
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	held_entry_t                ram_wdata;
	logic [AW-1:0]              ram_raddr;
	held_entry_t                ram_rdata;

	krhp_ram #(
		.WIDTH ($bits(held_entry_t)),
		.DEPTH (HELD_SLOTS)
	) u_held (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic                       in_fire;
	logic                       emit_ok;
	logic [CW-1:0]              last_idx;
	logic                       pin_ok;
	map_pair_t                  cur_pair;
	logic [CODE_W-1:0]          cmp_lhs;
	logic                       cmp_eq;
	logic                       mscan_live;
	logic                       scan_live;
	logic signed [ACC_W-1:0]    prod;
	logic signed [ACC_W-1:0]    acc_sum;
	logic                       round_up;
	logic signed [CLICKS_W-1:0] clicks_n;
	logic signed [REM_W-1:0]    rem_n;
	logic signed [HIRES_W-1:0]  hires_n;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign emit_ok   = !out_valid_q || out_ready;
	assign last_idx  = count_q - CW'(1);
	assign pin_ok    = (val_q != KEY_RELEASE) && (count_q < CW'(HELD_SLOTS));
	assign scan_live = (scan_q < count_q);

	// shared 10-bit comparator: held entries during the held walk,
	// remap sources during the map walk
	assign cur_pair   = pair_q[mscan_q[MIW-1:0]];
	assign mscan_live = (mscan_q < lim_q);
	assign cmp_lhs    = (state_q == S_HSCAN) ? ram_rdata.phys : cur_pair.source;
	assign cmp_eq     = (cmp_lhs == phys_q);

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = scan_q[AW-1:0];
		case (state_q)
			S_RDLAST: begin
				ram_raddr = last_idx[AW-1:0];
			end
			S_MOVE: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
			end
			S_PIN: begin
				ram_we         = 1'b1;
				ram_waddr      = count_q[AW-1:0];
				ram_wdata.virt = to_q;
				ram_wdata.phys = phys_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// wheel arithmetic
	assign prod     = $signed({{(ACC_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q})
			* $signed({{(ACC_W-SPEED_W){speed_q[SPEED_W-1]}}, speed_q});
	assign acc_sum  = $signed({{(ACC_W-REM_W){rem_q[REM_W-1]}}, rem_q}) + prod;
	// divide by 256 toward zero: floor, then bump negatives with a fraction
	assign round_up = acc_q[ACC_W-1] && (acc_q[7:0] != 8'd0);
	assign clicks_n = $signed(acc_q[ACC_W-1:8]) + $signed({{(CLICKS_W-1){1'b0}}, round_up});
	assign rem_n    = $signed({round_up, acc_q[7:0]});
	assign hires_n  = $signed({{(HIRES_W-CLICKS_W){clicks_q[CLICKS_W-1]}}, clicks_q})
			* CLICK_HIRES;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_count_q <= '0;
			speed_q     <= SPEED_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_MAP_COUNT) begin
				map_count_q <= cfg_wdata[MAP_CNT_W-1:0];
			end
			if (cfg_index == REG_SCROLL_SPEED) begin
				speed_q <= cfg_wdata[SPEED_W-1:0];
			end
		end
	end

	for (genvar j = 0; j < MAP_ENTRIES; j++) begin : g_pair
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pair_q[j] <= '0;
			end else if (cfg_we && (cfg_index == CFG_IDX_W'(REG_MAP_PAIR0 + j))) begin
				pair_q[j] <= cfg_wdata;
			end
		end
	end

	// capture the accepted transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q  <= mode;
			phys_q  <= key_code;
			val_q   <= key_value;
			delta_q <= wheel_delta;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			rem_q      <= '0;
			scan_q     <= '0;
			rd_pend_s1 <= 1'b0;
			found_q    <= 1'b0;
			mscan_q    <= '0;
			lim_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						scan_q     <= '0;
						rd_pend_s1 <= 1'b0;
						found_q    <= 1'b0;
						state_q    <= (mode == MODE_WHEEL) ? S_WMUL : S_HSCAN;
					end
				end
				S_HSCAN: begin
					rd_pend_s1 <= scan_live;
					if (scan_live) begin
						scan_q <= scan_q + CW'(1);
					end
					// last match wins
					if (rd_pend_s1 && cmp_eq) begin
						found_q <= 1'b1;
					end
					if (!scan_live && !rd_pend_s1) begin
						if (found_q) begin
							state_q <= (val_q == KEY_RELEASE) ? S_RDLAST : S_EMIT;
						end else begin
							mscan_q <= '0;
							lim_q   <= (map_count_q > MAP_CNT_W'(MAP_ENTRIES))
									? MAP_CNT_W'(MAP_ENTRIES) : map_count_q;
							state_q <= S_MSCAN;
						end
					end
				end
				S_RDLAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					count_q <= last_idx;
					state_q <= S_EMIT;
				end
				S_MSCAN: begin
					// first match wins; stop on a hit or at the end
					if (mscan_live && !cmp_eq) begin
						mscan_q <= mscan_q + MAP_CNT_W'(1);
					end else begin
						state_q <= pin_ok ? S_PIN : S_EMIT;
					end
				end
				S_PIN: begin
					count_q <= count_q + CW'(1);
					state_q <= S_EMIT;
				end
				S_WMUL: begin
					state_q <= (delta_q == '0) ? S_IDLE : S_WDIV;
				end
				S_WDIV: begin
					rem_q   <= rem_n;
					state_q <= (clicks_n == '0) ? S_IDLE : S_WHI;
				end
				S_WHI: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				to_q <= key_code;
			end
			S_HSCAN: begin
				rd_idx_s1 <= scan_q[AW-1:0];
				if (rd_pend_s1 && cmp_eq) begin
					idx_q <= rd_idx_s1;
					to_q  <= ram_rdata.virt;
				end
			end
			S_MSCAN: begin
				if (mscan_live && cmp_eq) begin
					to_q <= cur_pair.target;
				end
			end
			S_WMUL: begin
				acc_q <= acc_sum;
			end
			S_WDIV: begin
				clicks_q <= clicks_n;
			end
			S_WHI: begin
				hires_q <= hires_n;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && emit_ok) begin
			if (mode_q == MODE_KEY) begin
				kind_o_q   <= KIND_KEY;
				code_o_q   <= to_q;
				value_o_q  <= val_q;
				clicks_o_q <= '0;
				hires_o_q  <= '0;
			end else begin
				kind_o_q   <= KIND_SCROLL;
				code_o_q   <= '0;
				value_o_q  <= '0;
				clicks_o_q <= clicks_q;
				hires_o_q  <= hires_q;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = kind_o_q;
	assign virtual_code  = code_o_q;
	assign virtual_value = value_o_q;
	assign scroll_clicks = clicks_o_q;
	assign scroll_hires  = hires_o_q;

`ifndef SYNTHESIS
	// held table never overflows
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HELD_SLOTS))
		else $error("held count above table size");

	// only pin and unpin steps write the held table
	a_ram_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_PIN || state_q == S_MOVE))
		else $error("held table written outside pin/unpin");

	// an unpin only happens with at least one pinned entry
	a_unpin_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDLAST) |-> (count_q != '0))
		else $error("unpin with empty held table");

	// a pin adds exactly one entry
	a_pin_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PIN) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("pin did not grow held count");

	// fractional remainder stays strictly inside one click
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != $signed({1'b1, 8'd0}))
		else $error("wheel remainder out of range");
`endif

endmodule
